/* src/stp_pkg.sv */
// Shared types and constants for the stepper move pulse generator.
// No dependencies; imported by stp_datapath, stp_ctrl and the top module.
package stp_pkg;

	// operation codes carried in s_tuser
	localparam logic OP_MOVE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// configuration register indexes
	localparam logic REG_DEADBAND = 1'b0;
	localparam logic REG_WINDOW   = 1'b1;

	localparam int DEADBAND_RST = 20;
	localparam int WINDOW_RST   = 50000;

	// window/(8N) == (window>>3)/N, so the divider sees window without its low bits
	localparam int WIN_SHIFT = 3;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} stp_state_t;

	// controller -> datapath
	typedef struct packed {
		logic step_item;  // apply an accepted word and load the result register
		logic div_start;  // accepted move command that needs a period division
		logic div_load;   // division finished: load period and the result register
	} stp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_div;
		logic div_done;
	} stp_status_t;

endpackage

/* src/stp_divider.sv */
// Iterative restoring divider, one quotient bit per cycle.
// No dependencies.
module stp_divider #(
	parameter int DIVIDEND_WIDTH = 21,
	parameter int DIVISOR_WIDTH  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [DIVIDEND_WIDTH-1:0] dividend,
	input  logic [DIVISOR_WIDTH-1:0]  divisor,
	output logic                      done,
	output logic [DIVIDEND_WIDTH-1:0] quotient
);
	localparam int CNT_W = $clog2(DIVIDEND_WIDTH + 1);

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [DIVISOR_WIDTH-1:0]  rem_q;
	logic [DIVISOR_WIDTH-1:0]  dsr_q;
	logic [DIVIDEND_WIDTH-1:0] quo_q;

	logic [DIVISOR_WIDTH:0]   trial;
	logic                     ge;
	logic [DIVISOR_WIDTH:0]   diff;
	logic [DIVISOR_WIDTH-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, quo_q[DIVIDEND_WIDTH-1]};
		ge      = trial >= {1'b0, dsr_q};
		diff    = trial - {1'b0, dsr_q};
		// remainder stays below the divisor, so the top bit drops out
		rem_nxt = ge ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[DIVIDEND_WIDTH-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* src/stp_datapath.sv */
// Datapath: config registers, motion state, pulse timing and result register.
// Depends on stp_pkg and stp_divider.
module stp_datapath #(
	parameter int POS_WIDTH  = 16,
	parameter int TIME_WIDTH = 24,
	parameter int CFG_W      = 24,
	parameter int IN_W       = 32,
	parameter int OUT_W      = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 s_tuser,
	input  logic [IN_W-1:0]      s_tdata,
	input  stp_pkg::stp_cmd_t    cmd,
	output stp_pkg::stp_status_t status,
	output logic [OUT_W-1:0]     m_tdata
);
	import stp_pkg::*;

	localparam int DIVIDEND_W = TIME_WIDTH - WIN_SHIFT;

	logic [POS_WIDTH-1:0]  deadband_q;
	logic [TIME_WIDTH-1:0] window_q;

	logic                  cw_q, ccw_q, step_q, holding_q, active_q;
	logic [POS_WIDTH-1:0]  pulses_q;
	logic [TIME_WIDTH-1:0] half_q;
	logic [TIME_WIDTH-1:0] tick_q;
	logic [POS_WIDTH-1:0]  final_q;
	logic [OUT_W-1:0]      res_q;

	logic [POS_WIDTH-1:0] cur, tgt, n_abs;
	logic                 op, is_hold;

	logic                  step_n, holding_n, active_n, done_n;
	logic [POS_WIDTH-1:0]  pulses_n, final_n, pulses_dec;
	logic [TIME_WIDTH-1:0] tick_n, tick_dec;

	logic                  div_done;
	logic [DIVIDEND_W-1:0] quo;
	logic [TIME_WIDTH-1:0] hp_sat;

	assign cur     = s_tdata[POS_WIDTH-1:0];
	assign tgt     = s_tdata[2*POS_WIDTH-1:POS_WIDTH];
	assign op      = s_tuser;
	assign n_abs   = (tgt >= cur) ? (tgt - cur) : (cur - tgt);
	assign is_hold = (n_abs <= deadband_q) && (tgt != '0);

	assign status.need_div = (op == OP_MOVE) && !active_q && (n_abs != '0) && !is_hold;
	assign status.div_done = div_done;

	stp_divider #(
		.DIVIDEND_WIDTH(DIVIDEND_W),
		.DIVISOR_WIDTH (POS_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(window_q[TIME_WIDTH-1:WIN_SHIFT]),
		.divisor (n_abs),
		.done    (div_done),
		.quotient(quo)
	);

	assign hp_sat = (quo == '0) ? TIME_WIDTH'(1) : TIME_WIDTH'(quo);

	// next state for words that need no division (ticks, ignored, zero and hold moves)
	always_comb begin
		step_n     = step_q;
		holding_n  = holding_q;
		active_n   = active_q;
		pulses_n   = pulses_q;
		tick_n     = tick_q;
		final_n    = final_q;
		done_n     = 1'b0;
		tick_dec   = (tick_q != '0) ? (tick_q - TIME_WIDTH'(1)) : '0;
		pulses_dec = (pulses_q != '0) ? (pulses_q - POS_WIDTH'(1)) : '0;
		if (op == OP_MOVE) begin
			if (!active_q) begin
				if (n_abs == '0) begin
					final_n = cur;
					done_n  = 1'b1;
				end else if (is_hold) begin
					holding_n = 1'b1;
					active_n  = 1'b1;
					tick_n    = (window_q == '0) ? TIME_WIDTH'(1) : window_q;
					final_n   = cur;
				end
			end
		end else if (active_q) begin
			tick_n = tick_dec;
			if (tick_dec == '0) begin
				if (holding_q) begin
					holding_n = 1'b0;
					active_n  = 1'b0;
					done_n    = 1'b1;
				end else if (step_q) begin
					step_n = 1'b0;
					tick_n = half_q;
				end else begin
					pulses_n = pulses_dec;
					if (pulses_dec == '0) begin
						active_n = 1'b0;
						done_n   = 1'b1;
					end else begin
						step_n = 1'b1;
						tick_n = half_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= POS_WIDTH'(DEADBAND_RST);
			window_q   <= TIME_WIDTH'(WINDOW_RST);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_DEADBAND: deadband_q <= cfg_wdata[POS_WIDTH-1:0];
				REG_WINDOW:   window_q   <= cfg_wdata[TIME_WIDTH-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q      <= 1'b0;
			ccw_q     <= 1'b0;
			step_q    <= 1'b0;
			holding_q <= 1'b0;
			active_q  <= 1'b0;
			pulses_q  <= '0;
			half_q    <= '0;
			tick_q    <= '0;
			final_q   <= '0;
		end else if (cmd.step_item) begin
			step_q    <= step_n;
			holding_q <= holding_n;
			active_q  <= active_n;
			pulses_q  <= pulses_n;
			tick_q    <= tick_n;
			final_q   <= final_n;
		end else if (cmd.div_start) begin
			cw_q      <= (tgt > cur);
			ccw_q     <= !(tgt > cur);
			pulses_q  <= n_abs;
			final_q   <= tgt;
			step_q    <= 1'b1;
			holding_q <= 1'b0;
			active_q  <= 1'b1;
		end else if (cmd.div_load) begin
			half_q <= hp_sat;
			tick_q <= hp_sat;
		end
	end

	// result word: step, cw, ccw, busy, done, position; pad bits above are zero
	always_ff @(posedge clk) begin
		if (cmd.step_item) begin
			res_q <= OUT_W'({(done_n ? final_n : POS_WIDTH'(0)), done_n, active_n,
				ccw_q, cw_q, step_n});
		end else if (cmd.div_load) begin
			res_q <= OUT_W'({POS_WIDTH'(0), 1'b0, 1'b1, ccw_q, cw_q, 1'b1});
		end
	end

	assign m_tdata = res_q;

endmodule

/* src/stp_ctrl.sv */
// Controller: handshake, sequencing of the period division, output valid.
// Depends on stp_pkg.
module stp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  stp_pkg::stp_status_t status,
	output stp_pkg::stp_cmd_t    cmd
);
	import stp_pkg::*;

	stp_state_t state_q, state_n;
	logic       out_vld_q;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE) && (!out_vld_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && status.need_div) state_n = ST_DIV;
			ST_DIV:  if (status.div_done) state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.step_item = accept && !status.need_div;
				cmd.div_start = accept && status.need_div;
			end
			ST_DIV: begin
				cmd.div_load = status.div_done;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_n;
			// result register is free whenever a division ends (it drained at accept)
			if (cmd.step_item || cmd.div_load)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;

endmodule

/* src/stepper_move_pulse_generator.sv */
// Stepper move pulse generator: ticks and move commands in, pin levels and status out.
// Ticks, ignored commands, zero and hold moves: one word per cycle while m_tready is high,
// result valid in the next cycle. Moves that pulse run a serial divider for the half period
// on the TIME_WIDTH-3 upper bits of window: the result is loaded when the division is done,
// and the next word can be accepted only after that, once the controller is back in idle.
// Reset clears all motion state; deadband resets to 20 steps, window to 50000 us.
// Depends on stp_pkg, stp_ctrl, stp_datapath, stp_divider.
module stepper_move_pulse_generator #(
	parameter int POS_WIDTH  = 16,
	parameter int TIME_WIDTH = 24
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                          cfg_we,
	input  logic                                          cfg_addr,
	input  logic [((POS_WIDTH > TIME_WIDTH) ? POS_WIDTH : TIME_WIDTH)-1:0] cfg_wdata,

	input  logic                                          s_tvalid,
	output logic                                          s_tready,
	// current_pos, target_pos
	input  logic [((2*POS_WIDTH+7)/8)*8-1:0]              s_tdata,
	// operation
	input  logic                                          s_tuser,

	output logic                                          m_tvalid,
	input  logic                                          m_tready,
	// step_level, dir_cw, dir_ccw, busy_res, done_res, position
	output logic [((5+POS_WIDTH+7)/8)*8-1:0]              m_tdata
);
	import stp_pkg::*;

	localparam int CFG_W = (POS_WIDTH > TIME_WIDTH) ? POS_WIDTH : TIME_WIDTH;
	localparam int IN_W  = ((2*POS_WIDTH+7)/8)*8;
	localparam int OUT_W = ((5+POS_WIDTH+7)/8)*8;

	stp_cmd_t    cmd;
	stp_status_t status;

	stp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.status  (status),
		.cmd     (cmd)
	);

	stp_datapath #(
		.POS_WIDTH (POS_WIDTH),
		.TIME_WIDTH(TIME_WIDTH),
		.CFG_W     (CFG_W),
		.IN_W      (IN_W),
		.OUT_W     (OUT_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.status   (status),
		.m_tdata  (m_tdata)
	);

endmodule
